### rtl/core/oahi_pkg.sv
`timescale 1ns / 1ps
// shared codes and field widths of the open-addressing hash insert engine
package oahi_pkg;

  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned RIDX_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned P2_W      = 10;
  localparam int unsigned MODE_W    = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_READ     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PRIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE    = 2'd2;

  localparam logic [CFG_W-1:0]  TABLE_SIZE_RST   = 11'd1021;
  localparam logic [P2_W-1:0]   SECOND_PRIME_RST = 10'd1019;
  localparam logic [MODE_W-1:0] PROBE_MODE_RST   = MODE_LINEAR;

endpackage

### rtl/core/oahi_mod_unit.sv
`timescale 1ns / 1ps
// restoring remainder unit, one dividend bit per cycle
module oahi_mod_unit #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;

  logic [DW:0]   shifted;
  logic [DW-1:0] rem_nx;

  always_comb begin
    shifted = {rem_q, num_q[NW-1]};
    if (shifted >= {1'b0, div_q}) begin
      rem_nx = DW'(shifted - {1'b0, div_q});
    end else begin
      rem_nx = shifted[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
        num_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_nx;
        num_q <= {num_q[NW-2:0], 1'b0};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (div_q != '0) |-> rem_q < div_q)
    else $error("remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_o)
    else $error("divide ended without done");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q)
    else $error("done raised while still iterating");

endmodule

### rtl/core/oahi_slot_ram.sv
`timescale 1ns / 1ps
// slot store: one write port, one read port with registered data
module oahi_slot_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned AW     = 10,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/open_addressing_hash_insert.sv
`timescale 1ns / 1ps
// open-addressing hash table insert engine, top level
//
// input channel (in_valid_i / in_stall_o) takes one word: an insert of key_i or
// a read of slot read_index_i, chosen by opcode_i. output channel
// (out_valid_o / out_stall_i) gives one result word per input word.
// configuration writes (cfg_valid_i / cfg_ready_o) set table size, second
// prime and probe mode by register index; they are always taken, and are
// meant to be written while no word is in flight.
// one word is worked on at a time. a read passes from accept through S_RREQ
// (address) and S_RDAT (registered data) to S_DONE and the output register.
// an insert first forms the home remainder (in double hashing two more
// remainders follow, key mod second prime and then step mod size), then
// probes: each probe reads the slot store and checks the registered data
// before the next address is formed; S_DONE then loads the output register.
// after reset the slot store is cleared, one entry per cycle, all TABLE_DEPTH
// entries, with in_stall_o high. a finished result waits in the output
// register while the receiver stalls; the next word is still accepted, and
// its result is held until the output register frees.
module open_addressing_hash_insert #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [oahi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [oahi_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [KEY_WIDTH-1:0]                key_i,
  input  logic [oahi_pkg::RIDX_W-1:0]         read_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [oahi_pkg::STATUS_W-1:0]       status_o,
  output logic [oahi_pkg::SLOT_W-1:0]         slot_o,
  output logic [oahi_pkg::CNT_W-1:0]          collisions_o,
  output logic [KEY_WIDTH-1:0]                read_value_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned XW = (AW > oahi_pkg::CNT_W) ? AW : oahi_pkg::CNT_W;
  localparam int unsigned NW = (KEY_WIDTH > XW) ? KEY_WIDTH : XW;
  localparam logic [XW:0]   DEPTH_X = (XW + 1)'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HOME  = 4'd2;
  localparam logic [3:0] S_P2    = 4'd3;
  localparam logic [3:0] S_STEP  = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_RREQ  = 4'd7;
  localparam logic [3:0] S_RDAT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                      state_q;
  logic [AW-1:0]                   clr_q;
  logic [oahi_pkg::CFG_W-1:0]      table_size_q;
  logic [oahi_pkg::P2_W-1:0]       second_prime_q;
  logic [oahi_pkg::MODE_W-1:0]     probe_mode_q;
  logic [KEY_WIDTH-1:0]            key_q;
  logic [oahi_pkg::RIDX_W-1:0]     ridx_q;
  logic [XW-1:0]                   m_q;
  logic [oahi_pkg::P2_W-1:0]       p2_q;
  logic [oahi_pkg::MODE_W-1:0]     mode_q;
  logic [XW-1:0]                   idx_q;
  logic [XW-1:0]                   d_q;
  logic [oahi_pkg::CNT_W-1:0]      coll_q;
  logic [oahi_pkg::STATUS_W-1:0]   res_status_q;
  logic [oahi_pkg::SLOT_W-1:0]     res_slot_q;
  logic [oahi_pkg::CNT_W-1:0]      res_coll_q;
  logic [KEY_WIDTH-1:0]            res_val_q;
  logic                            out_valid_q;
  logic [oahi_pkg::STATUS_W-1:0]   out_status_q;
  logic [oahi_pkg::SLOT_W-1:0]     out_slot_q;
  logic [oahi_pkg::CNT_W-1:0]      out_coll_q;
  logic [KEY_WIDTH-1:0]            out_val_q;

  logic                            in_accept;
  logic                            out_free;
  logic                            out_load;
  logic [XW-1:0]                   ts_x;
  logic [XW-1:0]                   m_eff;
  logic [oahi_pkg::P2_W-1:0]       p2_eff;
  logic [XW-1:0]                   ridx_x;
  logic                            ridx_ok;
  logic [XW:0]                     idx_sum;
  logic [XW-1:0]                   idx_nx;
  logic [XW:0]                     d_sum;
  logic [XW-1:0]                   d_nx;
  logic [oahi_pkg::CNT_W-1:0]      coll_nx;
  logic                            probe_full;
  logic                            slot_empty;

  logic                            div_start;
  logic [NW-1:0]                   div_num;
  logic [XW-1:0]                   div_den;
  logic                            div_done;
  logic [XW-1:0]                   div_rem;

  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [KEY_WIDTH-1:0]            wr_data;
  logic [AW-1:0]                   rd_addr;
  logic [KEY_WIDTH-1:0]            rd_data;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_DONE) && out_free;
  assign cfg_ready_o = 1'b1;

  // size zero acts as one, sizes above the store saturate; a zero second prime acts as one
  always_comb begin
    ts_x = XW'(table_size_q);
    if (table_size_q == '0) begin
      m_eff = XW'(1);
    end else if ({1'b0, ts_x} > DEPTH_X) begin
      m_eff = DEPTH_X[XW-1:0];
    end else begin
      m_eff = ts_x;
    end
    p2_eff = (second_prime_q == '0) ? oahi_pkg::P2_W'(1) : second_prime_q;
  end

  assign ridx_x  = XW'(ridx_q);
  assign ridx_ok = ({1'b0, ridx_x} < DEPTH_X);

  // next probe index: add the running step and fold once, both stay below m
  always_comb begin
    idx_sum = {1'b0, idx_q} + {1'b0, d_q};
    if (idx_sum >= {1'b0, m_q}) begin
      idx_nx = XW'(idx_sum - {1'b0, m_q});
    end else begin
      idx_nx = idx_sum[XW-1:0];
    end
    // quadratic: the gap between successive squares grows by two
    d_sum = {1'b0, d_q} + (XW + 1)'(2);
    if (d_sum >= {1'b0, m_q}) begin
      d_nx = XW'(d_sum - {1'b0, m_q});
    end else begin
      d_nx = d_sum[XW-1:0];
    end
  end

  assign coll_nx    = coll_q + oahi_pkg::CNT_W'(1);
  assign probe_full = (XW'(coll_nx) == m_q);
  assign slot_empty = (rd_data == '0);

  // remainder unit requests: home slot, key mod second prime, step mod size
  always_comb begin
    div_start = 1'b0;
    div_num   = NW'({1'b0, div_rem} + (XW + 1)'(1));
    div_den   = m_q;
    case (state_q)
      S_IDLE: begin
        div_start = in_accept && (opcode_i == oahi_pkg::OP_INSERT);
        div_num   = NW'(key_i);
        div_den   = m_eff;
      end
      S_HOME: begin
        div_start = div_done && (mode_q == oahi_pkg::MODE_DOUBLE);
        div_num   = NW'(key_q);
        div_den   = XW'(p2_q);
      end
      S_P2: begin
        div_start = div_done;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  oahi_mod_unit #(
    .NW(NW),
    .DW(XW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  assign wr_en   = (state_q == S_CLEAR) || ((state_q == S_PCHK) && slot_empty);
  assign wr_addr = (state_q == S_CLEAR) ? clr_q : idx_q[AW-1:0];
  assign wr_data = (state_q == S_CLEAR) ? '0 : key_q;
  assign rd_addr = (state_q == S_RREQ) ? ridx_x[AW-1:0] : idx_q[AW-1:0];

  oahi_slot_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DATA_W(KEY_WIDTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q   <= oahi_pkg::TABLE_SIZE_RST;
      second_prime_q <= oahi_pkg::SECOND_PRIME_RST;
      probe_mode_q   <= oahi_pkg::PROBE_MODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        oahi_pkg::CFG_TABLE_SIZE:   table_size_q   <= cfg_data_i;
        oahi_pkg::CFG_SECOND_PRIME: second_prime_q <= cfg_data_i[oahi_pkg::P2_W-1:0];
        oahi_pkg::CFG_PROBE_MODE:   probe_mode_q   <= cfg_data_i[oahi_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      key_q        <= '0;
      ridx_q       <= '0;
      m_q          <= '0;
      p2_q         <= '0;
      mode_q       <= '0;
      idx_q        <= '0;
      d_q          <= '0;
      coll_q       <= '0;
      res_status_q <= '0;
      res_slot_q   <= '0;
      res_coll_q   <= '0;
      res_val_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_coll_q   <= '0;
      out_val_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LAST_ADDR) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            key_q  <= key_i;
            ridx_q <= read_index_i;
            m_q    <= m_eff;
            p2_q   <= p2_eff;
            mode_q <= probe_mode_q;
            coll_q <= '0;
            d_q    <= XW'(1);
            state_q <= (opcode_i == oahi_pkg::OP_READ) ? S_RREQ : S_HOME;
          end
        end
        S_HOME: begin
          if (div_done) begin
            idx_q   <= div_rem;
            state_q <= (mode_q == oahi_pkg::MODE_DOUBLE) ? S_P2 : S_PRD;
          end
        end
        S_P2: begin
          if (div_done) begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (div_done) begin
            d_q     <= div_rem;
            state_q <= S_PRD;
          end
        end
        S_PRD: begin
          state_q <= S_PCHK;
        end
        S_PCHK: begin
          if (slot_empty) begin
            res_status_q <= oahi_pkg::ST_INSERTED;
            res_slot_q   <= idx_q[oahi_pkg::SLOT_W-1:0];
            res_coll_q   <= coll_q;
            res_val_q    <= '0;
            state_q      <= S_DONE;
          end else if (probe_full) begin
            res_status_q <= oahi_pkg::ST_FULL;
            res_slot_q   <= '0;
            res_coll_q   <= m_q[oahi_pkg::CNT_W-1:0];
            res_val_q    <= '0;
            state_q      <= S_DONE;
          end else begin
            coll_q <= coll_nx;
            idx_q  <= idx_nx;
            if (mode_q == oahi_pkg::MODE_QUADRATIC) begin
              d_q <= d_nx;
            end
            state_q <= S_PRD;
          end
        end
        S_RREQ: begin
          state_q <= S_RDAT;
        end
        S_RDAT: begin
          res_status_q <= oahi_pkg::ST_READ;
          res_slot_q   <= ridx_q;
          res_coll_q   <= '0;
          res_val_q    <= ridx_ok ? rd_data : '0;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            out_coll_q   <= res_coll_q;
            out_val_q    <= res_val_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_o       = out_slot_q;
  assign collisions_o = out_coll_q;
  assign read_value_o = out_val_q;

  a_probe_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCHK) |-> (idx_q < m_q))
    else $error("probe index beyond table size");

  a_probe_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCHK) |-> (XW'(coll_q) < m_q))
    else $error("probe count reached table size");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result word raised outside completion");

endmodule

### tb/hash_insert_monitor.sv
`timescale 1ns / 1ps
// predicts every result of the hash insert engine from its input, configuration and slot words
module hash_insert_monitor #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [oahi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [oahi_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           opcode_i,
  input  logic [KEY_WIDTH-1:0]           key_i,
  input  logic [oahi_pkg::RIDX_W-1:0]    read_index_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [oahi_pkg::STATUS_W-1:0]  status_i,
  input  logic [oahi_pkg::SLOT_W-1:0]    slot_i,
  input  logic [oahi_pkg::CNT_W-1:0]     collisions_i,
  input  logic [KEY_WIDTH-1:0]           read_value_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  import oahi_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_W-1:0]     collisions;
    logic [KEY_WIDTH-1:0] read_value;
  } hash_result_t;

  logic [KEY_WIDTH-1:0] slot_copy [TABLE_DEPTH];
  logic [CFG_W-1:0]     size_q;
  logic [P2_W-1:0]      prime_q;
  logic [MODE_W-1:0]    mode_q;
  hash_result_t         due_results [$];
  hash_result_t         want;
  int unsigned          errors;

  // walks the probe sequence of the current mode and places the key in the first empty slot
  function automatic hash_result_t place_key(input logic [KEY_WIDTH-1:0] key);
    int unsigned  m;
    int unsigned  home;
    int unsigned  step;
    int unsigned  h;
    hash_result_t res;
    m = (size_q == 0) ? 1 : ((size_q > TABLE_DEPTH) ? TABLE_DEPTH : size_q);
    home = key % m;
    step = (prime_q == 0) ? 1 : prime_q;
    step = (key % step) + 1;
    res.status = ST_FULL;
    res.slot = '0;
    res.collisions = m[CNT_W-1:0];
    res.read_value = '0;
    for (int unsigned i = 0; i < m; i++) begin
      case (mode_q)
        MODE_QUADRATIC: h = (home + i * i) % m;
        MODE_DOUBLE:    h = (home + i * step) % m;
        default:        h = (home + i) % m;
      endcase
      if (slot_copy[h] == '0) begin
        // a zero key lands here too, and the slot still reads as empty
        slot_copy[h] = key;
        res.status = ST_INSERTED;
        res.slot = h[SLOT_W-1:0];
        res.collisions = i[CNT_W-1:0];
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TABLE_DEPTH; j++) slot_copy[j] = '0;
      size_q = TABLE_SIZE_RST;
      prime_q = SECOND_PRIME_RST;
      mode_q = PROBE_MODE_RST;
      due_results.delete();
      errors = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TABLE_SIZE:   size_q = cfg_data_i;
          CFG_SECOND_PRIME: prime_q = cfg_data_i[P2_W-1:0];
          CFG_PROBE_MODE:   mode_q = cfg_data_i[MODE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d", status_i, slot_i);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            errors++;
          end
          if (slot_i !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, slot_i);
            errors++;
          end
          if (collisions_i !== want.collisions) begin
            $error("collisions: expected %0d, actual %0d", want.collisions, collisions_i);
            errors++;
          end
          if (read_value_i !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, read_value_i);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_READ) begin
          want.status = ST_READ;
          want.slot = read_index_i;
          want.collisions = '0;
          want.read_value = slot_copy[read_index_i];
        end else begin
          want = place_key(key_i);
        end
        due_results.push_back(want);
      end
      pending_o <= due_results.size();
      fail_count_o <= errors;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for the open-addressing hash insert engine
module testbench;
  import oahi_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned KEY_WIDTH   = 16;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 165;
  localparam longint unsigned CYCLE_LIMIT = 64'd25_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_RESERVED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = OP_INSERT;
  logic [KEY_WIDTH-1:0]  key = '0;
  logic [RIDX_W-1:0]     read_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_W-1:0]     slot;
  logic [CNT_W-1:0]      collisions;
  logic [KEY_WIDTH-1:0]  read_value;
  int unsigned           pending;
  int unsigned           fail_count;
  longint unsigned       cycles = 0;
  int unsigned           stall_left = 0;
  int unsigned           stall_roll;
  int unsigned           span = 1021;
  logic                  quiet = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  open_addressing_hash_insert #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .key_i       (key),
    .read_index_i(read_index),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .slot_o      (slot),
    .collisions_o(collisions),
    .read_value_o(read_value)
  );

  hash_insert_monitor #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) i_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .opcode_i    (opcode),
    .key_i       (key),
    .read_index_i(read_index),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .status_i    (status),
    .slot_i      (slot),
    .collisions_i(collisions),
    .read_value_i(read_value),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // receiver back-pressure: short bursts mostly, now and then a long stall or a clean stretch
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 40) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else if (stall_roll < 85) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_roll < 95) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(20, 80);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(20, 100);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // called at a rising edge, returns at the edge that takes the word, or later after a random idle gap
  task automatic send_word(input logic op, input logic [KEY_WIDTH-1:0] k,
                           input logic [RIDX_W-1:0] ridx);
    int unsigned roll;
    int unsigned gap;
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    read_index <= ridx;
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
  endtask

  // registers only change with nothing in flight
  task automatic drain();
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned          size_data;
    int unsigned          prime_data;
    int unsigned          hi;
    int unsigned          roll;
    int unsigned          start;
    logic [CFG_IDX_W-1:0] idx;
    logic                 op;
    logic [KEY_WIDTH-1:0] k;
    logic [RIDX_W-1:0]    ridx;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero key, wrap to home zero, collisions, top key, reads in and past range
    send_word(OP_INSERT, '0, '0);
    send_word(OP_INSERT, KEY_WIDTH'(1021), '0);
    send_word(OP_INSERT, KEY_WIDTH'(2042), '0);
    send_word(OP_INSERT, '1, '0);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_READ, '0, '0);
    send_word(OP_READ, '0, '1);
    send_word(OP_READ, '0, RIDX_W'(191));
    send_word(OP_READ, '0, RIDX_W'(1022));
    in_valid <= 1'b0;

    // oversized table saturates, quadratic probing, write to an unused index
    drain();
    write_reg(CFG_TABLE_SIZE, '1);
    write_reg(CFG_PROBE_MODE, CFG_W'(MODE_QUADRATIC));
    write_reg(CFG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_word(OP_INSERT, KEY_WIDTH'(1024), '0);
    send_word(OP_READ, '0, RIDX_W'(4));
    in_valid <= 1'b0;

    // size zero acts as one slot, already taken
    drain();
    write_reg(CFG_TABLE_SIZE, '0);
    cfg_valid <= 1'b0;
    send_word(OP_INSERT, KEY_WIDTH'(5), '0);
    in_valid <= 1'b0;

    // double hashing with prime zero on a full two-slot table
    drain();
    write_reg(CFG_TABLE_SIZE, CFG_W'(2));
    write_reg(CFG_PROBE_MODE, CFG_W'(MODE_DOUBLE));
    write_reg(CFG_SECOND_PRIME, '0);
    cfg_valid <= 1'b0;
    send_word(OP_INSERT, KEY_WIDTH'(3), '0);
    in_valid <= 1'b0;

    // reserved mode behaves as linear
    drain();
    write_reg(CFG_TABLE_SIZE, CFG_W'(5));
    write_reg(CFG_PROBE_MODE, CFG_W'(MODE_RESERVED));
    cfg_valid <= 1'b0;
    send_word(OP_INSERT, KEY_WIDTH'(7), '0);
    send_word(OP_INSERT, KEY_WIDTH'(12), '0);
    send_word(OP_READ, '0, RIDX_W'(3));
    send_word(OP_INSERT, '1, '0);
    send_word(OP_READ, '0, RIDX_W'(2));
    in_valid <= 1'b0;

    // sizes grow over the first eight phases, as slots are never freed; the last four vary
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 8) begin
        hi = 8 << p;
        if (hi > 1023) hi = 1023;
        size_data = $urandom_range((hi / 4 < 2) ? 2 : hi / 4, hi);
      end else begin
        case (p)
          8:       size_data = $urandom_range(TABLE_DEPTH, 2047);
          9:       size_data = $urandom_range(0, 1);
          10:      size_data = TABLE_SIZE_RST;
          default: size_data = $urandom_range(2, 1023);
        endcase
      end
      span = (size_data == 0) ? 1 : ((size_data > TABLE_DEPTH) ? TABLE_DEPTH : size_data);
      roll = $urandom_range(0, 5);
      if (roll == 0) prime_data = 0;
      else if (roll == 1) prime_data = 1;
      else if (roll == 2) prime_data = 1023 + ($urandom_range(0, 1) << 10);
      else prime_data = $urandom_range(0, 2047);
      start = $urandom_range(0, 2);
      for (int r = 0; r < 3; r++) begin
        idx = CFG_IDX_W'((start + r) % 3);
        case (idx)
          CFG_TABLE_SIZE:   write_reg(idx, CFG_W'(size_data));
          CFG_SECOND_PRIME: write_reg(idx, CFG_W'(prime_data));
          default:          write_reg(idx, CFG_W'($urandom_range(0, 2047)));
        endcase
      end
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 2047)));
      cfg_valid <= 1'b0;
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_READ;
        roll = $urandom_range(0, 29);
        if (roll == 0) k = '0;
        else if (roll == 1) k = '1;
        else k = KEY_WIDTH'($urandom_range(0, (1 << KEY_WIDTH) - 1));
        if ($urandom_range(0, 9) < 6) ridx = RIDX_W'($urandom_range(0, span - 1));
        else ridx = RIDX_W'($urandom_range(0, (1 << RIDX_W) - 1));
        send_word(op, k, ridx);
      end
      in_valid <= 1'b0;
      quiet = 1'b0;
    end

    do @(negedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
